@@ rtl/core/json_string_escaper_assert.svh @@
// ----------------------------------------------------------------------------
// JSON string escaper assertion macros
// Clocked property checks; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define JSE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define JSE_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define JSE_ASSERT(label, clk, rst, prop, msg)
`define JSE_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ rtl/core/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper package
// Widths, character codes and the types shared between the escaper modules.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int COUNT_BITS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int BYTE_BITS  = 8;
   localparam int MAX_SEQ    = 6;
   localparam int LEN_BITS   = $clog2(MAX_SEQ + 1);
   localparam int IDX_BITS   = $clog2(MAX_SEQ);
   // Compare width: holds the clamped size and position plus an escape.
   localparam int CMP_BITS   = ((COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS) + 1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(129);

   localparam logic [BYTE_BITS-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_BITS-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB       = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [BYTE_BITS-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [BYTE_BITS-1:0] CHAR_SLASH     = 8'h2F;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_BSLASH    = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_U   = 8'h75;

   typedef logic [MAX_SEQ-1:0][BYTE_BITS-1:0] seq_type;

   // Per-string tracking state.
   typedef struct packed {
      logic [COUNT_BITS-1:0] position;
      logic                  failed;
      logic                  stopped;
   } str_state_type;

   // Characters to send for one request.
   typedef struct packed {
      logic [LEN_BITS-1:0] len;
      seq_type             chars;
   } escape_type;

endpackage

@@ rtl/core/json_string_escaper.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper
// Escapes a zero-terminated byte string for JSON within a bounded buffer.
// ----------------------------------------------------------------------------
//
//   channel   ports                         direction  moves
//   request   req_valid/req_ready/req_in_byte   in     one source byte
//   response  rsp_valid/rsp_ready/rsp_out_char  out    one output character
//   config    csr_wr_en/csr_wr_data             in     buffer size, no wait
//
// A request is decided in the cycle it is accepted; its characters are held
// in the output sequencer and, while rsp_ready is high, leave one per cycle
// from the next cycle on, and plain bytes sustain one request per cycle. An
// escape loads 2 or 6 characters, and a dropped byte produces nothing.
// req_ready is high while the sequencer is empty or handing over its last
// character; a stalled response therefore holds off further requests.
// Synchronous active-high reset clears string state and sets size to 129.
//
`include "json_string_escaper_assert.svh"

module json_string_escaper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jse_pkg::BYTE_BITS-1:0] req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [jse_pkg::BYTE_BITS-1:0] rsp_out_char,
   input  logic                          csr_wr_en,
   input  logic [jse_pkg::SIZE_BITS-1:0] csr_wr_data
);

   logic [jse_pkg::SIZE_BITS-1:0] size_ff;
   jse_pkg::str_state_type        state_ff;
   jse_pkg::str_state_type        state_in;
   jse_pkg::escape_type           escape;
   logic                          can_load;
   logic                          req_take;

   assign req_ready = can_load;
   assign req_take  = req_valid && req_ready;

   // Decide the request directly from the port and the current string state.
   jse_step u_step (
      .in_byte     (req_in_byte),
      .buffer_size (size_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .escape      (escape)
   );

   // Hold the characters and hand them out one per cycle while rsp_ready is high.
   jse_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .escape    (escape),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_char  (rsp_out_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= jse_pkg::SIZE_RESET;
         state_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         // Advance string state only on an accepted request.
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   `JSE_ASSERT(a_end_clears, clock, reset, (req_take && (req_in_byte == jse_pkg::CHAR_NUL)) |=> (state_ff == '0), "string state not cleared at end")
   `JSE_NEVER(a_fail_silent, clock, reset, req_take && !state_ff.failed && state_in.failed && (escape.len != '0), "failing escape produced characters")
   `JSE_ASSERT(a_idle_hold, clock, reset, !req_take |=> $stable(state_ff), "string state moved without request")

endmodule

@@ rtl/core/jse_step.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper step logic
// Classifies one byte and decides its output characters and next string state.
// ----------------------------------------------------------------------------
module jse_step (
   input  logic [jse_pkg::BYTE_BITS-1:0] in_byte,
   input  logic [jse_pkg::SIZE_BITS-1:0] buffer_size,
   input  jse_pkg::str_state_type        state_cur,
   output jse_pkg::str_state_type        state_nxt,
   output jse_pkg::escape_type           escape
);

   localparam logic [jse_pkg::CMP_BITS-1:0] CAP = jse_pkg::CMP_BITS'(1) << jse_pkg::COUNT_BITS;

   function automatic logic [jse_pkg::BYTE_BITS-1:0] hex_char(input logic [3:0] nib);
      logic [jse_pkg::BYTE_BITS-1:0] ch;
      if (nib < 4'd10) begin
         ch = jse_pkg::CHAR_ZERO + jse_pkg::BYTE_BITS'(nib);
      end else begin
         ch = jse_pkg::CHAR_LOWER_A + jse_pkg::BYTE_BITS'(nib - 4'd10);
      end
      return ch;
   endfunction

   function automatic jse_pkg::escape_type classify(input logic [jse_pkg::BYTE_BITS-1:0] b);
      jse_pkg::escape_type e;
      e.chars    = '0;
      e.len      = jse_pkg::LEN_BITS'(2);
      e.chars[0] = jse_pkg::CHAR_BSLASH;
      case (b)
         jse_pkg::CHAR_QUOTE:     e.chars[1] = jse_pkg::CHAR_QUOTE;
         jse_pkg::CHAR_BSLASH:    e.chars[1] = jse_pkg::CHAR_BSLASH;
         jse_pkg::CHAR_SLASH:     e.chars[1] = jse_pkg::CHAR_SLASH;
         jse_pkg::CHAR_BACKSPACE: e.chars[1] = jse_pkg::CHAR_LOWER_B;
         jse_pkg::CHAR_FORMFEED:  e.chars[1] = jse_pkg::CHAR_LOWER_F;
         jse_pkg::CHAR_NEWLINE:   e.chars[1] = jse_pkg::CHAR_LOWER_N;
         jse_pkg::CHAR_RETURN:    e.chars[1] = jse_pkg::CHAR_LOWER_R;
         jse_pkg::CHAR_TAB:       e.chars[1] = jse_pkg::CHAR_LOWER_T;
         default: begin
            if (b < jse_pkg::CHAR_SPACE) begin
               e.len      = jse_pkg::LEN_BITS'(6);
               e.chars[1] = jse_pkg::CHAR_LOWER_U;
               e.chars[2] = jse_pkg::CHAR_ZERO;
               e.chars[3] = jse_pkg::CHAR_ZERO;
               e.chars[4] = hex_char(b[7:4]);
               e.chars[5] = hex_char(b[3:0]);
            end else begin
               e.len      = jse_pkg::LEN_BITS'(1);
               e.chars[0] = b;
            end
         end
      endcase
      return e;
   endfunction

   logic [jse_pkg::CMP_BITS-1:0] size_ext;
   logic [jse_pkg::CMP_BITS-1:0] size_eff;
   logic [jse_pkg::CMP_BITS-1:0] pos_ext;
   logic [jse_pkg::CMP_BITS-1:0] pos_end;
   jse_pkg::escape_type          cls;

   assign size_ext = jse_pkg::CMP_BITS'(buffer_size);
   assign size_eff = (size_ext > CAP) ? CAP : size_ext;
   assign pos_ext  = jse_pkg::CMP_BITS'(state_cur.position);
   assign cls      = classify(in_byte);
   assign pos_end  = pos_ext + jse_pkg::CMP_BITS'(cls.len);

   always_comb begin
      state_nxt    = state_cur;
      escape.len   = '0;
      escape.chars = cls.chars;
      if (in_byte == jse_pkg::CHAR_NUL) begin
         // End of string: terminator only for a clean string, then start over.
         escape.chars[0] = jse_pkg::CHAR_NUL;
         if (!state_cur.failed && (size_eff != '0) && (pos_ext < size_eff)) begin
            escape.len = jse_pkg::LEN_BITS'(1);
         end
         state_nxt = '0;
      end else if (state_cur.failed || state_cur.stopped) begin
         // drop
      end else if ((size_eff == '0) || (pos_ext + jse_pkg::CMP_BITS'(1) >= size_eff)) begin
         state_nxt.stopped = 1'b1;
      end else if ((cls.len > jse_pkg::LEN_BITS'(1)) && (pos_end >= size_eff)) begin
         state_nxt.failed = 1'b1;
      end else begin
         escape.len         = cls.len;
         state_nxt.position = jse_pkg::COUNT_BITS'(pos_end);
      end
   end

endmodule

@@ rtl/core/jse_emit.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper output sequencer
// Holds one request's characters and sends them one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "json_string_escaper_assert.svh"

module jse_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  jse_pkg::escape_type           escape,
   output logic                          can_load,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [jse_pkg::BYTE_BITS-1:0] out_char
);

   logic                         busy_ff;
   logic                         busy_in;
   logic [jse_pkg::IDX_BITS-1:0] idx_ff;
   logic [jse_pkg::IDX_BITS-1:0] idx_in;
   logic [jse_pkg::LEN_BITS-1:0] len_ff;
   logic [jse_pkg::LEN_BITS-1:0] len_in;
   jse_pkg::seq_type             seq_ff;
   jse_pkg::seq_type             seq_in;
   logic                         last;
   logic                         take;

   assign last      = (jse_pkg::LEN_BITS'(idx_ff) == len_ff - jse_pkg::LEN_BITS'(1));
   assign take      = busy_ff && out_ready;
   assign can_load  = !busy_ff || (take && last);
   assign out_valid = busy_ff;
   assign out_char  = seq_ff[idx_ff];

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      seq_in  = seq_ff;
      if (take) begin
         idx_in = idx_ff + jse_pkg::IDX_BITS'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load && (escape.len != '0)) begin
         busy_in = 1'b1;
         idx_in  = '0;
         len_in  = escape.len;
         seq_in  = escape.chars;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         len_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         len_ff  <= len_in;
      end
      seq_ff <= seq_in;
   end

   `JSE_ASSERT(a_idx_in_range, clock, reset, busy_ff |-> (jse_pkg::LEN_BITS'(idx_ff) < len_ff), "emit index past length")
   `JSE_ASSERT(a_stall_holds, clock, reset, (busy_ff && !out_ready) |=> (busy_ff && $stable(idx_ff) && $stable(out_char)), "stalled character moved")
   `JSE_ASSERT(a_last_drains, clock, reset, (take && last && !load) |=> !busy_ff, "sequencer busy after last character")

endmodule
